### hw/rtl/jsu_pkg.sv
// shared types and constants for the json string unescape block
`timescale 1ns / 1ps

package jsu_pkg;

  localparam int MAX_RESULTS = 3;

  localparam logic [7:0] CHAR_QUOTE     = 8'h22;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_SLASH     = 8'h2F;
  localparam logic [7:0] CHAR_LOWER_B   = 8'h62;
  localparam logic [7:0] CHAR_LOWER_F   = 8'h66;
  localparam logic [7:0] CHAR_LOWER_N   = 8'h6E;
  localparam logic [7:0] CHAR_LOWER_R   = 8'h72;
  localparam logic [7:0] CHAR_LOWER_T   = 8'h74;
  localparam logic [7:0] CHAR_LOWER_U   = 8'h75;

  localparam logic [7:0] CTRL_BS = 8'h08;
  localparam logic [7:0] CTRL_FF = 8'h0C;
  localparam logic [7:0] CTRL_LF = 8'h0A;
  localparam logic [7:0] CTRL_CR = 8'h0D;
  localparam logic [7:0] CTRL_HT = 8'h09;

  localparam logic [7:0]  UTF8_LEAD2  = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD3  = 8'hE0;
  localparam logic [7:0]  UTF8_CONT   = 8'h80;
  localparam logic [15:0] UTF8_LIMIT1 = 16'h0080;
  localparam logic [15:0] UTF8_LIMIT2 = 16'h0800;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_END  = 1'b1;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    MODE_IDLE = 4'b0001,
    MODE_STR  = 4'b0010,
    MODE_ESC  = 4'b0100,
    MODE_HEX  = 4'b1000
  } mode_t;

  // one classified request: up to three result bytes and how many are used
  typedef struct packed {
    logic [1:0]                  count;
    kind_t                       kind;
    logic [MAX_RESULTS-1:0][7:0] bytes;
  } job_t;

  // hex digit value, with a flag for a byte that is no hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    begin
      if (c >= 8'h30 && c <= 8'h39) begin
        r = {1'b0, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
        r = {1'b0, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
        r = {1'b0, 4'(c - 8'h37)};
      end else begin
        r = 5'b10000;
      end
      return r;
    end
  endfunction

endpackage

### hw/rtl/jsu_if.sv
// stream channel interfaces for text input and decoded output
`timescale 1ns / 1ps

interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] char_in;

  modport source (output valid, output cmd, output char_in, input ready);
  modport sink (input valid, input cmd, input char_in, output ready);
endinterface

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic       last;

  modport source (output valid, output out_byte, output out_kind, output last, input ready);
  modport sink (input valid, input out_byte, input out_kind, input last, output ready);
endinterface

### hw/rtl/jsu_front.sv
// front end: accepts text requests, runs the string state machine, builds jobs
`timescale 1ns / 1ps

module jsu_front
  import jsu_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  jsu_in_if.sink       text,
  output logic         push,
  output job_t         push_job,
  input  logic         push_ready
);

  mode_t       mode, mode_next;
  logic [1:0]  hex_count, hex_count_next;
  logic [15:0] code_point, code_point_next;
  logic        bad_hex, bad_hex_next;

  logic        accept;
  logic [4:0]  hv;
  logic [15:0] cp_new;

  assign text.ready = push_ready;
  assign accept     = text.valid && push_ready;
  assign hv         = hex_value(text.char_in);
  assign cp_new     = {code_point[11:0], hv[3:0]};

  always_comb begin
    mode_next       = mode;
    hex_count_next  = hex_count;
    code_point_next = code_point;
    bad_hex_next    = bad_hex;
    push            = 1'b0;
    push_job.count  = 2'd1;
    push_job.kind   = KIND_ERROR;
    push_job.bytes  = '0;

    case (mode)
      MODE_IDLE: begin
        if (text.cmd == CMD_BYTE) begin
          if (text.char_in == CHAR_QUOTE) begin
            mode_next = MODE_STR;
          end else begin
            push = 1'b1;
          end
        end
      end
      MODE_STR: begin
        if (text.cmd == CMD_END) begin
          push = 1'b1;
        end else if (text.char_in == CHAR_QUOTE) begin
          push          = 1'b1;
          push_job.kind = bad_hex ? KIND_ERROR : KIND_CLOSE;
        end else if (text.char_in == CHAR_BACKSLASH) begin
          mode_next = MODE_ESC;
        end else begin
          push              = 1'b1;
          push_job.kind     = KIND_DATA;
          push_job.bytes[0] = text.char_in;
        end
      end
      MODE_ESC: begin
        push = 1'b1;
        if (text.cmd == CMD_BYTE) begin
          push_job.kind = KIND_DATA;
          mode_next     = MODE_STR;
          case (text.char_in)
            CHAR_QUOTE:     push_job.bytes[0] = CHAR_QUOTE;
            CHAR_BACKSLASH: push_job.bytes[0] = CHAR_BACKSLASH;
            CHAR_SLASH:     push_job.bytes[0] = CHAR_SLASH;
            CHAR_LOWER_B:   push_job.bytes[0] = CTRL_BS;
            CHAR_LOWER_F:   push_job.bytes[0] = CTRL_FF;
            CHAR_LOWER_N:   push_job.bytes[0] = CTRL_LF;
            CHAR_LOWER_R:   push_job.bytes[0] = CTRL_CR;
            CHAR_LOWER_T:   push_job.bytes[0] = CTRL_HT;
            CHAR_LOWER_U: begin
              push            = 1'b0;
              mode_next       = MODE_HEX;
              hex_count_next  = 2'd0;
              code_point_next = '0;
            end
            default: begin
              push_job.kind = KIND_ERROR;
              mode_next     = MODE_IDLE;
            end
          endcase
        end
      end
      MODE_HEX: begin
        if (text.cmd == CMD_END) begin
          push = 1'b1;
        end else begin
          bad_hex_next = bad_hex | hv[4];
          if (hex_count != 2'd3) begin
            hex_count_next  = hex_count + 2'd1;
            code_point_next = cp_new;
          end else begin
            hex_count_next  = 2'd0;
            code_point_next = '0;
            mode_next       = MODE_STR;
            push            = 1'b1;
            push_job.kind   = KIND_DATA;
            // utf-8 encode, one to three bytes
            if (cp_new < UTF8_LIMIT1) begin
              push_job.bytes[0] = cp_new[7:0];
            end else if (cp_new < UTF8_LIMIT2) begin
              push_job.count    = 2'd2;
              push_job.bytes[0] = UTF8_LEAD2 | {3'b000, cp_new[10:6]};
              push_job.bytes[1] = UTF8_CONT | {2'b00, cp_new[5:0]};
            end else begin
              push_job.count    = 2'd3;
              push_job.bytes[0] = UTF8_LEAD3 | {4'b0000, cp_new[15:12]};
              push_job.bytes[1] = UTF8_CONT | {2'b00, cp_new[11:6]};
              push_job.bytes[2] = UTF8_CONT | {2'b00, cp_new[5:0]};
            end
          end
        end
      end
      default: begin
        mode_next = MODE_IDLE;
      end
    endcase

    // errors and closes drop everything and return to idle
    if (push && push_job.kind != KIND_DATA) begin
      mode_next       = MODE_IDLE;
      hex_count_next  = 2'd0;
      code_point_next = '0;
      bad_hex_next    = 1'b0;
    end

    if (!accept) begin
      push = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      hex_count  <= 2'd0;
      code_point <= '0;
      bad_hex    <= 1'b0;
    end else if (accept) begin
      mode       <= mode_next;
      hex_count  <= hex_count_next;
      code_point <= code_point_next;
      bad_hex    <= bad_hex_next;
    end
  end

endmodule

### hw/rtl/jsu_queue.sv
// small register fifo of jobs between front and back
`timescale 1ns / 1ps

module jsu_queue
  import jsu_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  input  job_t wr_job,
  output logic wr_ready,
  output logic rd_valid,
  output job_t rd_job,
  input  logic rd_pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr, do_rd;

  assign wr_ready = (count != FULL_CNT);
  assign rd_valid = (count != '0);
  assign rd_job   = mem[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_pop && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/jsu_back.sv
// back end: walks the bytes of each job out as single results
`timescale 1ns / 1ps

module jsu_back
  import jsu_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     job_valid,
  input  job_t     job,
  output logic     job_pop,
  jsu_out_if.source result
);

  logic [1:0] idx;
  logic       is_last;
  logic       fire;

  assign is_last         = (idx == job.count - 2'd1);
  assign fire            = result.valid && result.ready;
  assign result.valid    = job_valid;
  assign result.out_byte = job.bytes[idx];
  assign result.out_kind = job.kind;
  assign result.last     = is_last;
  assign job_pop         = fire && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (fire) begin
      idx <= is_last ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

### hw/rtl/json_string_unescape_top.sv
// top level of the streaming json string unescape block
`timescale 1ns / 1ps

// json string unescape: takes a json string literal one text byte per request
// on the text channel and gives decoded bytes on the result channel. an
// opening quote starts a string; plain bytes pass through, backslash escapes
// become their bytes, and a \u escape gathers four hex digits and gives one to
// three utf-8 bytes (no surrogate pairing). a closing quote gives a close
// result, or an error if a bad hex digit was seen; malformed input gives an
// error and returns to idle. the last result caused by one text request has
// last set. a text request is taken every cycle while the job queue has room;
// a queued job gives one result per cycle while the result port is ready, so
// a \u escape that closes into a two or three byte sequence holds the result
// port for one result per byte and the queue (QUEUE_DEPTH jobs) absorbs the
// difference. a job is registered in the queue before its first result shows.

module json_string_unescape_top
  import jsu_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  jsu_in_if.sink     text,
  jsu_out_if.source  result
);

  // front to queue
  logic push;
  logic push_ready;
  job_t push_job;

  // queue to back
  logic head_valid;
  logic head_pop;
  job_t head_job;

  // classify each text request and keep the string state
  jsu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .text       (text),
    .push       (push),
    .push_job   (push_job),
    .push_ready (push_ready)
  );

  // decouples input acceptance from multi-byte output
  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push),
    .wr_job   (push_job),
    .wr_ready (push_ready),
    .rd_valid (head_valid),
    .rd_job   (head_job),
    .rd_pop   (head_pop)
  );

  // serialize job bytes to the result channel
  jsu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (head_valid),
    .job       (head_job),
    .job_pop   (head_pop),
    .result    (result)
  );

endmodule
